[hw/rtl/ssd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types and constants of the staggered slew dimmer.
// ----------------------------------------------------------------------------
package ssd_pkg;

    localparam int CHANNELS = 6;
    localparam int CH_AW    = $clog2(CHANNELS);
    localparam int CNT_W    = $clog2(CHANNELS + 1);

    localparam logic [1:0] OP_SET  = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_OFF  = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    localparam logic [2:0] REG_STAGGER = 3'd0;
    localparam logic [2:0] REG_LARGE   = 3'd1;
    localparam logic [2:0] REG_RAMP    = 3'd2;
    localparam logic [2:0] REG_FULL    = 3'd3;
    localparam logic [2:0] REG_BOARDS  = 3'd4;

    localparam logic [23:0] MAX_FX    = 24'hFF0000;
    localparam logic [18:0] HOLD_MAX  = 19'h7FFFF;
    localparam logic [15:0] STAGGER_RST = 16'd500;
    localparam logic [23:0] MV_RND    = 24'd8355840;
    localparam logic [22:0] MV_RECIP  = 23'd4210753;

    typedef struct packed {
        logic [1:0]  op;
        logic [2:0]  channel;
        logic [7:0]  value;
        logic [31:0] now_ms;
    } t_in;

    typedef struct packed {
        logic [2:0]  out_channel;
        logic [13:0] millivolts;
        logic        last;
    } t_out;

    typedef struct packed {
        logic [23:0] level;
        logic [7:0]  target_level;
        logic [31:0] hold_start;
        logic [18:0] hold_length;
    } t_ent;

    localparam int ENT_W = $bits(t_ent);

    function automatic logic [18:0] hold_rst(input logic [CH_AW-1:0] c);
        logic [31:0] h;
        h = 32'(c) * 32'(STAGGER_RST);
        return (h > 32'(HOLD_MAX)) ? HOLD_MAX : h[18:0];
    endfunction

endpackage

[hw/rtl/staggered_slew_dimmer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// staggered_slew_dimmer_unit
// Six-channel dimmer with slew limit and staggered ramp-up.
// ----------------------------------------------------------------------------
// One word at a time. Channel state lives in a one-port-read RAM and is
// walked channel by channel: a set target reads each channel, then writes one,
// an all off clears each target, and a tick runs the bit-serial step divider
// (skipped when the elapsed time reaches the ramp time), then steps each channel
// and reports changed ones on enabled boards, waiting out output stalls. Entries not
// yet written read as their reset values, no clearing pass is needed.
module staggered_slew_dimmer_unit
    import ssd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SRD  = 4'd1;
    localparam logic [3:0] ST_SACC = 4'd2;
    localparam logic [3:0] ST_SWR  = 4'd3;
    localparam logic [3:0] ST_ORD  = 4'd4;
    localparam logic [3:0] ST_OWR  = 4'd5;
    localparam logic [3:0] ST_DIV  = 4'd6;
    localparam logic [3:0] ST_TRD  = 4'd7;
    localparam logic [3:0] ST_TUPD = 4'd8;
    localparam logic [3:0] ST_MV1  = 4'd9;
    localparam logic [3:0] ST_MV2  = 4'd10;
    localparam logic [3:0] ST_EMIT = 4'd11;
    localparam logic [3:0] ST_TNXT = 4'd12;
    localparam logic [3:0] ST_LAST = 4'd13;

    logic [3:0]       r_st, n_st;
    logic [15:0]      r_stagger;
    logic [7:0]       r_large;
    logic [15:0]      r_ramp;
    logic [13:0]      r_full;
    logic [2:0]       r_boards;
    logic [31:0]      r_last_tick;
    t_in              r_in;
    logic [CH_AW-1:0] r_ch;
    logic [CH_AW-1:0] r_rd_addr;
    logic [CHANNELS-1:0] r_init;
    logic [CNT_W-1:0] r_cnt;
    t_ent             r_ent;
    logic [39:0]      r_num;
    logic [15:0]      r_rem;
    logic [23:0]      r_q;
    logic [5:0]       r_dcnt;
    logic [23:0]      r_step;
    logic [23:0]      r_lvl;
    logic [21:0]      r_x;
    logic [13:0]      r_mv;
    logic             r_pend_v;
    logic [2:0]       r_pend_ch;
    logic [13:0]      r_pend_mv;

    logic             ram_we;
    logic [CH_AW-1:0] ram_waddr;
    t_ent             ram_wdata;
    logic [CH_AW-1:0] ram_raddr;
    logic [ENT_W-1:0] ram_rdata;
    t_ent             ent;

    logic [15:0] rm;
    logic [31:0] dt;
    logic        held;
    logic [23:0] tgt;
    logic        rising;
    logic        falling;
    logic [23:0] new_lvl;
    logic        changed;
    logic        board_ok;
    logic [16:0] rem2;
    logic        q_bit;
    logic [31:0] h32;
    logic [18:0] h_sat;
    logic [9:0]  diff;
    logic        big;
    logic        ch_last;
    logic [37:0] prod_fs;
    logic [44:0] prod_rc;

    ssd_ram #(.W(ENT_W), .D(CHANNELS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // unwritten entries read as reset values
    always_comb begin
        if (r_init[r_rd_addr]) begin
            ent = t_ent'(ram_rdata);
        end else begin
            ent = '{level: '0, target_level: '0, hold_start: '0,
                    hold_length: hold_rst(r_rd_addr)};
        end
    end

    assign rm      = (r_ramp == 16'd0) ? 16'd1 : r_ramp;
    assign dt      = i_in.now_ms - r_last_tick;
    assign held    = ((r_in.now_ms - ent.hold_start) < 32'(ent.hold_length));
    assign tgt     = {ent.target_level, 16'd0};
    assign rising  = ent.level < tgt;
    assign falling = ent.level > tgt;
    assign ch_last = (r_ch == CH_AW'(CHANNELS - 1));
    assign board_ok = (32'(r_ch) / 2 < 3) && r_boards[2'(32'(r_ch) / 2)];

    always_comb begin
        new_lvl = ent.level;
        changed = 1'b0;
        if (rising) begin
            if (!held) begin
                changed = 1'b1;
                new_lvl = ((tgt - ent.level) <= r_step) ? tgt : ent.level + r_step;
            end
        end else if (falling) begin
            changed = 1'b1;
            new_lvl = ((ent.level - tgt) <= r_step) ? tgt : ent.level - r_step;
        end
    end

    assign rem2  = {r_rem, r_num[39]};
    assign q_bit = rem2 >= {1'b0, rm};

    assign h32   = 32'(r_cnt) * 32'(r_stagger);
    assign h_sat = (h32 > 32'(HOLD_MAX)) ? HOLD_MAX : h32[18:0];
    assign diff  = {2'b0, r_in.value} - {2'b0, r_ent.level[23:16]};
    assign big   = (r_in.value > r_ent.target_level) && !diff[9]
                   && (diff[8:0] > {1'b0, r_large});

    assign prod_fs = 38'(r_lvl) * 38'(r_full);
    assign prod_rc = 45'(r_x) * 45'(MV_RECIP);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_ch;
        ram_wdata = ent;
        ram_raddr = r_ch;
        case (r_st)
            ST_SWR: begin
                ram_we    = 1'b1;
                ram_waddr = CH_AW'(r_in.channel);
                ram_wdata = r_ent;
                ram_wdata.target_level = r_in.value;
                if (big) begin
                    ram_wdata.hold_start  = r_in.now_ms;
                    ram_wdata.hold_length = h_sat;
                end
            end
            ST_OWR: begin
                ram_we = 1'b1;
                ram_wdata.target_level = '0;
                ram_wdata.hold_length  = '0;
            end
            ST_TUPD: begin
                ram_we = changed;
                ram_wdata.level = new_lvl;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_in.op)
                        OP_SET:  n_st = (32'(i_in.channel) < CHANNELS) ? ST_SRD : ST_IDLE;
                        OP_TICK: begin
                            if (dt == 32'd0) begin
                                n_st = ST_IDLE;
                            end else if (dt >= 32'(rm)) begin
                                n_st = ST_TRD;
                            end else begin
                                n_st = ST_DIV;
                            end
                        end
                        OP_OFF:  n_st = ST_ORD;
                        default: n_st = ST_IDLE;
                    endcase
                end
            end
            ST_SRD:  n_st = ST_SACC;
            ST_SACC: n_st = ch_last ? ST_SWR : ST_SRD;
            ST_SWR:  n_st = ST_IDLE;
            ST_ORD:  n_st = ST_OWR;
            ST_OWR:  n_st = ch_last ? ST_IDLE : ST_ORD;
            ST_DIV:  n_st = (r_dcnt == 6'd39) ? ST_TRD : ST_DIV;
            ST_TRD:  n_st = ST_TUPD;
            ST_TUPD: n_st = (changed && board_ok) ? ST_MV1 : ST_TNXT;
            ST_MV1:  n_st = ST_MV2;
            ST_MV2:  n_st = r_pend_v ? ST_EMIT : ST_TNXT;
            ST_EMIT: n_st = i_out_ready ? ST_TNXT : ST_EMIT;
            ST_TNXT: begin
                if (ch_last) begin
                    n_st = r_pend_v ? ST_LAST : ST_IDLE;
                end else begin
                    n_st = ST_TRD;
                end
            end
            ST_LAST: n_st = i_out_ready ? ST_IDLE : ST_LAST;
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= ST_IDLE;
            r_stagger   <= STAGGER_RST;
            r_large     <= 8'd64;
            r_ramp      <= 16'd1000;
            r_full      <= 14'd10000;
            r_boards    <= 3'd7;
            r_last_tick <= '0;
            r_init      <= '0;
            r_pend_v    <= 1'b0;
        end else begin
            r_st <= n_st;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_STAGGER: r_stagger <= i_cfg_data;
                    REG_LARGE:   r_large   <= i_cfg_data[7:0];
                    REG_RAMP:    r_ramp    <= i_cfg_data;
                    REG_FULL:    r_full    <= i_cfg_data[13:0];
                    REG_BOARDS:  r_boards  <= i_cfg_data[2:0];
                    default:     r_boards  <= r_boards;
                endcase
            end
            if (r_st == ST_IDLE && i_in_valid && i_in.op == OP_TICK && dt != 32'd0) begin
                r_last_tick <= i_in.now_ms;
                r_pend_v    <= 1'b0;
            end
            if (ram_we) begin
                r_init[ram_waddr] <= 1'b1;
            end
            if (r_st == ST_MV2 && !r_pend_v) begin
                r_pend_v <= 1'b1;
            end
            if (r_st == ST_LAST && i_out_ready) begin
                r_pend_v <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_rd_addr <= ram_raddr;
        case (r_st)
            ST_IDLE: begin
                r_in   <= i_in;
                r_ch   <= '0;
                r_cnt  <= '0;
                r_num  <= {(24'(i_in.now_ms[15:0] - r_last_tick[15:0]) * 24'd255), 16'd0};
                r_rem  <= '0;
                r_q    <= '0;
                r_dcnt <= '0;
                r_step <= MAX_FX;
            end
            ST_SACC: begin
                if (r_ch == CH_AW'(r_in.channel)) begin
                    r_ent <= ent;
                end else if (rising || held) begin
                    r_cnt <= r_cnt + 1'b1;
                end
                r_ch <= r_ch + 1'b1;
            end
            ST_OWR: begin
                r_ch <= r_ch + 1'b1;
            end
            ST_DIV: begin
                r_rem  <= q_bit ? 16'(rem2 - {1'b0, rm}) : rem2[15:0];
                r_num  <= {r_num[38:0], 1'b0};
                r_q    <= {r_q[22:0], q_bit};
                r_dcnt <= r_dcnt + 1'b1;
                if (r_dcnt == 6'd39) begin
                    r_step <= {r_q[22:0], q_bit};
                end
            end
            ST_TUPD: begin
                r_lvl <= new_lvl;
            end
            ST_MV1: begin
                r_x <= 22'((prod_fs + 38'(MV_RND)) >> 16);
            end
            ST_MV2: begin
                r_mv <= prod_rc[43:30];
                if (!r_pend_v) begin
                    r_pend_ch <= 3'(r_ch);
                    r_pend_mv <= prod_rc[43:30];
                end
            end
            ST_EMIT: begin
                if (i_out_ready) begin
                    r_pend_ch <= 3'(r_ch);
                    r_pend_mv <= r_mv;
                end
            end
            ST_TNXT: begin
                r_ch <= r_ch + 1'b1;
            end
            default: begin
                r_ch <= r_ch;
            end
        endcase
    end

    assign o_in_ready        = (r_st == ST_IDLE);
    assign o_cfg_ready       = 1'b1;
    assign o_out_valid       = (r_st == ST_EMIT) || (r_st == ST_LAST);
    assign o_out.out_channel = r_pend_ch;
    assign o_out.millivolts  = r_pend_mv;
    assign o_out.last        = (r_st == ST_LAST);
endmodule

[hw/rtl/ssd_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module ssd_ram #(
    parameter int W = 8,
    parameter int D = 8
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
